// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, disabled while reset is high
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_PROP_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_PROP_NR(lbl, clk, prop, msg)

`endif

`endif

// ===== design/csx_pkg.sv =====
// ----------------------------------------------------------------------------
// csx_pkg
// shared widths, codes and types of the call stack exclusive time profiler
// ----------------------------------------------------------------------------
package csx_pkg;

   localparam int CMD_W    = 2;
   localparam int ID_W     = 4;
   localparam int TS_W     = 32;
   localparam int TOT_W    = 32;
   localparam int STAT_W   = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_START = 2'd0,
      CMD_END   = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_BACK  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_UPDATE
   } state_type;

endpackage

// ===== design/csx_req_if.sv =====
// ----------------------------------------------------------------------------
// csx_req_if
// trace event channel: command, function id and timestamp
// ----------------------------------------------------------------------------
interface csx_req_if import csx_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [ID_W-1:0]   func_id;
   logic [TS_W-1:0]   timestamp;

   modport source (output valid, output cmd, output func_id, output timestamp,
                   input ready);
   modport sink   (input valid, input cmd, input func_id, input timestamp,
                   output ready);

endinterface

// ===== design/csx_rsp_if.sv =====
// ----------------------------------------------------------------------------
// csx_rsp_if
// result channel: function id, exclusive total and status
// ----------------------------------------------------------------------------
interface csx_rsp_if import csx_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   func_id_out;
   logic [TOT_W-1:0]  total_time;
   logic [STAT_W-1:0] status;

   modport source (output valid, output func_id_out, output total_time,
                   output status, input ready);
   modport sink   (input valid, input func_id_out, input total_time,
                   input status, output ready);

endinterface

// ===== design/call_stack_exclusive_time.sv =====
// ----------------------------------------------------------------------------
// call_stack_exclusive_time
// exclusive-time profiler for nested function calls over a parsed event trace
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one trace item per transfer: cmd start, end or read, the
//   function id and the event timestamp. every item gives exactly one transfer
//   on rsp_chan with the id, that function's exclusive total after the item
//   and a status (ok, end on empty stack, start on full stack, time backwards).
// sequence
//   an item passes accept (stack top and total of the id are read), lookup
//   (total of the charged function is read, slice math) and update (write
//   back, result loaded). the next item is taken only once the last has left
//   update. the order is set by the two dependent reads on the single read
//   port of the totals memory: the charged id is only known once the stack
//   memory has returned its top entry.
// reset
//   synchronous, active high. stack count and slice start go to zero, the
//   totals read as zero through one valid bit per entry, so there is no
//   clearing pass and the block takes items as soon as reset is released.
//   the stack memory needs no reset: only pushed entries are ever used.
// stalls
//   the result sits in an output register; the next item is accepted while
//   it waits. the update step holds until that register is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module call_stack_exclusive_time import csx_pkg::*; #(
   parameter int NUM_FUNCS   = 16,
   parameter int STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   csx_req_if.sink     req_chan,
   csx_rsp_if.source   rsp_chan
);

   // index widths
   localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int FW = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
   localparam int IW = (FW > ID_W) ? FW : ID_W;
   localparam logic [IW:0]   NF_LIM    = (IW+1)'(NUM_FUNCS);
   localparam logic [CW-1:0] DEPTH_LIM = CW'(STACK_DEPTH);

   // id is a function that has a totals entry
   function automatic logic id_ok(input logic [ID_W-1:0] id);
      logic [IW:0] ext;
      ext = (IW+1)'(id);
      return ext < NF_LIM;
   endfunction

   // totals memory index of an id
   function automatic logic [FW-1:0] id_idx(input logic [ID_W-1:0] id);
      logic [IW-1:0] ext;
      ext = IW'(id);
      return ext[FW-1:0];
   endfunction

   // sequencer
   state_type state_ff, state_in;
   logic      req_ready;
   logic      accept;
   logic      fire;

   // captured item
   logic [CMD_W-1:0]  cmd_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TS_W-1:0]   ts_ff;

   // architectural state
   logic [CW-1:0]     count_ff, count_in;
   logic [TS_W-1:0]   slice_ff, slice_in;

   // call stack memory
   logic [ID_W-1:0]   stack_mem [STACK_DEPTH];
   logic [ID_W-1:0]   top_ff;
   logic [CW-1:0]     top_ptr;

   // totals memory with per-entry valid bits
   logic [TOT_W-1:0]     tot_mem [NUM_FUNCS];
   logic [NUM_FUNCS-1:0] tot_vld_ff;
   logic [TOT_W-1:0]     tot_rd_ff;
   logic                 tot_rd_vld_ff;
   logic [TOT_W-1:0]     tot_rd;
   logic [FW-1:0]        tot_rd_addr;

   // lookup results
   logic                 is_start, is_end, full, empty;
   logic [TS_W:0]        end_next, mark, slice_ext;
   logic                 back;
   logic [ID_W-1:0]      chg_id;
   status_type           lk_status;
   logic                 lk_charge, lk_push, lk_pop;
   logic [TS_W-1:0]      lk_slice;

   logic [TOT_W-1:0]     tot_id_ff;
   logic [TS_W:0]        amount_ff;
   logic [FW-1:0]        chg_idx_ff;
   logic                 charge_ff, push_ff, pop_ff, match_ff, id_ok_ff;
   logic [STAT_W-1:0]    status_ff;
   logic [TS_W-1:0]      new_slice_ff;

   // update math
   logic [TOT_W+1:0]     sum;
   logic [TOT_W-1:0]     sat_total;
   logic [TOT_W-1:0]     out_total;

   // output register
   logic                 rsp_valid_ff;
   logic [ID_W-1:0]      rsp_id_ff;
   logic [TOT_W-1:0]     rsp_total_ff;
   logic [STAT_W-1:0]    rsp_status_ff;

   // ------------------------------------------------------------------------
   // state machine
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_LOOKUP;
         end
         S_LOOKUP: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (fire) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      fire      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_LOOKUP: begin
         end
         S_UPDATE: begin
            // result register free or being emptied this cycle
            fire = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
         end
      endcase
   end

   assign accept         = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture the item on its transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_chan.cmd;
         id_ff  <= req_chan.func_id;
         ts_ff  <= req_chan.timestamp;
      end
   end

   // ------------------------------------------------------------------------
   // call stack: top read at accept, push write at update
   // ------------------------------------------------------------------------
   assign top_ptr = count_ff - CW'(1);

   always_ff @(posedge clock) begin
      if (accept) begin
         // wraps when empty; the value is then never used
         top_ff <= stack_mem[top_ptr[SW-1:0]];
      end
      if (fire && push_ff) begin
         stack_mem[count_ff[SW-1:0]] <= id_ff;
      end
   end

   // ------------------------------------------------------------------------
   // totals memory: one read port (id at accept, charged id at lookup),
   // one write port at update
   assign tot_rd_addr = (state_ff == S_IDLE) ? id_idx(req_chan.func_id) : id_idx(chg_id);
   assign tot_rd      = tot_rd_vld_ff ? tot_rd_ff : '0;

   always_ff @(posedge clock) begin
      tot_rd_ff <= tot_mem[tot_rd_addr];
      if (fire && charge_ff) begin
         tot_mem[chg_idx_ff] <= sat_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tot_rd_vld_ff <= 1'b0;
         tot_vld_ff    <= '0;
      end else begin
         tot_rd_vld_ff <= tot_vld_ff[tot_rd_addr];
         if (fire && charge_ff) begin
            tot_vld_ff[chg_idx_ff] <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // lookup: stack checks, slice length and charge decision
   // ------------------------------------------------------------------------
   always_comb begin
      is_start  = (cmd_ff == CMD_START);
      is_end    = (cmd_ff == CMD_END);
      full      = (count_ff >= DEPTH_LIM);
      empty     = (count_ff == '0);
      slice_ext = {1'b0, slice_ff};
      end_next  = {1'b0, ts_ff} + (TS_W+1)'(1);
      // an end charges through its own tick inclusive
      mark      = is_end ? end_next : {1'b0, ts_ff};
      back      = (mark < slice_ext);
      // a start charges the caller on top of the stack, an end the named id
      chg_id    = is_start ? top_ff : id_ff;

      lk_status = STAT_OK;
      lk_charge = 1'b0;
      lk_push   = 1'b0;
      lk_pop    = 1'b0;
      lk_slice  = ts_ff;
      case (cmd_ff)
         CMD_START: begin
            if (full) begin
               lk_status = STAT_FULL;
            end else begin
               lk_push = 1'b1;
               if (back) lk_status = STAT_BACK;
               lk_charge = !back && !empty && id_ok(top_ff);
            end
         end
         CMD_END: begin
            if (empty) begin
               lk_status = STAT_EMPTY;
            end else begin
               lk_pop = 1'b1;
               if (back) lk_status = STAT_BACK;
               lk_charge = !back && id_ok(id_ff);
               // next slice opens one tick later, held at the top of range
               lk_slice  = end_next[TS_W] ? '1 : end_next[TS_W-1:0];
            end
         end
         default: begin
            // read, and the unused code acting as read
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_LOOKUP) begin
         tot_id_ff    <= tot_rd;
         amount_ff    <= mark - slice_ext;
         chg_idx_ff   <= id_idx(chg_id);
         charge_ff    <= lk_charge;
         push_ff      <= lk_push;
         pop_ff       <= lk_pop;
         match_ff     <= (chg_id == id_ff);
         id_ok_ff     <= id_ok(id_ff);
         status_ff    <= lk_status;
         new_slice_ff <= lk_slice;
      end
   end

   // ------------------------------------------------------------------------
   // update: saturating add, state write back, result load
   // ------------------------------------------------------------------------
   always_comb begin
      sum       = {2'b00, tot_rd} + {1'b0, amount_ff};
      sat_total = (|sum[TOT_W+1:TOT_W]) ? '1 : sum[TOT_W-1:0];
      if (!id_ok_ff) begin
         out_total = '0;
      end else if (charge_ff && match_ff) begin
         out_total = sat_total;
      end else begin
         out_total = tot_id_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      slice_in = slice_ff;
      if (fire) begin
         if (push_ff) count_in = count_ff + CW'(1);
         if (pop_ff)  count_in = count_ff - CW'(1);
         if (push_ff || pop_ff) slice_in = new_slice_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         slice_ff <= '0;
      end else begin
         count_ff <= count_in;
         slice_ff <= slice_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_id_ff     <= id_ff;
         rsp_total_ff  <= out_total;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.func_id_out = rsp_id_ff;
   assign rsp_chan.total_time  = rsp_total_ff;
   assign rsp_chan.status      = rsp_status_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   `ASSERT_PROP(a_accept_lookup, clock, reset, accept |=> (state_ff == S_LOOKUP), "accepted item did not enter lookup")
   `ASSERT_PROP(a_push_count, clock, reset, (fire && push_ff) |=> (count_ff == $past(count_ff) + CW'(1)), "push did not grow the stack")
   `ASSERT_PROP(a_stack_err_hold, clock, reset, (fire && (status_ff == STAT_EMPTY || status_ff == STAT_FULL)) |=> $stable(count_ff) && $stable(slice_ff), "stack error changed state")
   `ASSERT_PROP(a_total_grows, clock, reset, (fire && charge_ff) |-> (sat_total >= tot_rd), "charged total went down")
   `ASSERT_PROP_NR(a_count_bound, clock, reset || (count_ff <= DEPTH_LIM), "stack count beyond depth")

endmodule
